// ===== sv/chs_pkg.sv =====
// Package for the chained hash set engine: operation and status codes,
// channel payload types and the fixed hash constants.
// Depends on nothing; every other file but chs_entry_ram imports it.
package chs_pkg;

  localparam int KEY_W      = 64;
  localparam int VALUE_W    = 64;
  localparam int TOTAL_W    = 13;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int BKT_CFG_W  = 7;
  localparam int KLEN_CFG_W = 4;
  localparam int REM_W      = 9;
  localparam int TERM_W     = 31;
  localparam int SUM_W      = 34;
  localparam int MOD_W      = 36;
  localparam int MOD_STEPS  = MOD_W / 4;

  localparam logic [22:0] HASH_MUL = 23'd6678383;
  localparam logic [22:0] HASH_ADD = 23'd6618401;

  localparam logic [CFG_IDX_W-1:0] CFG_BUCKETS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEYLEN  = 1'd1;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_EMPTY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_DUP    = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [VALUE_W-1:0] value_out;
    logic [TOTAL_W-1:0] entry_total;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [3:0]       nbytes;
    logic [REM_W-1:0] divisor;
  } hash_ctl_t;

  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] rem;
  } hash_res_t;

endpackage

// ===== sv/chs_if.sv =====
// Valid/ready channel interfaces for the chained hash set engine.
// Depends on chs_pkg for the payload types.
interface chs_in_if;
  import chs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface chs_out_if;
  import chs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/chained_hash_set_engine.sv =====
// Chained hash set engine: a key/value table of buckets with transpose on a find or insert hit.
// Top level; depends on chs_pkg, chs_if, chs_hash and chs_entry_ram.
//
// Usage: the input channel carries one operation per transfer (op, key,
// value_in); the block answers each with exactly one result transfer on the
// output channel (status, value_out, entry_total). The configuration port
// writes bucket_count (index 0) and key_length (index 1); write it only while
// no operation is in flight.
// Timing: an operation occupies the block from its input transfer until its
// result transfer, and in_ready is low meanwhile. The hash starts, sums the
// hashed key bytes, takes the remainder by the bucket count and hands back the
// bucket; the bucket's fill is read in states S_FILL and S_FILL2; the scan
// reads and then compares each entry examined through the single read port of
// the entry memory. A transpose reads the predecessor and writes both entries
// back, a remove reads and writes each moved entry, and S_FIN commits before
// the result is offered. Empty-all offers its result in the cycle after its input.
// Reset: clears every bucket's fill through per-bucket valid bits, zeroes
// the pair count and restores bucket_count to 64 and key_length to 8. The
// block is ready as soon as reset is released; there is no clearing pass.
// Stall: the result is held in an output register; while out_ready is low it
// stays unchanged and no new input is taken.
module chained_hash_set_engine #(
  parameter int NUM_BUCKETS  = 64,
  parameter int BUCKET_DEPTH = 8,
  parameter int VALUE_WIDTH  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  chs_in_if.sink                        in_ch,
  chs_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [chs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [chs_pkg::CFG_W-1:0]     cfg_wdata
);
  import chs_pkg::*;

  localparam int SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int FW    = $clog2(BUCKET_DEPTH + 1);
  localparam int DW    = KEY_W + VALUE_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_FILL, S_FILL2, S_SCAN_RD, S_SCAN_CMP,
    S_SWAP_RD, S_SWAP_W1, S_SWAP_W2, S_RM_RD, S_RM_WR, S_FIN, S_OUT
  } state_t;

  typedef enum logic [1:0] {ACT_NONE, ACT_INC, ACT_DEC} act_t;

  // Configuration registers.
  logic [BKT_CFG_W-1:0]  bucket_count_r;
  logic [KLEN_CFG_W-1:0] key_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BKT_CFG_W'(64);
      key_length_r   <= KLEN_CFG_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUCKETS: bucket_count_r <= cfg_wdata[BKT_CFG_W-1:0];
        CFG_KEYLEN:  key_length_r   <= cfg_wdata[KLEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective settings: zero acts as one, large values saturate.
  logic [REM_W-1:0] eff_div;
  logic [3:0]       eff_bytes;
  logic [KEY_W-1:0] key_mask;

  always_comb begin
    if (bucket_count_r == '0) begin
      eff_div = REM_W'(1);
    end else if (REM_W'(bucket_count_r) > REM_W'(NUM_BUCKETS)) begin
      eff_div = REM_W'(NUM_BUCKETS);
    end else begin
      eff_div = REM_W'(bucket_count_r);
    end
    if (key_length_r == '0) begin
      eff_bytes = 4'd1;
    end else if (key_length_r > 4'd8) begin
      eff_bytes = 4'd8;
    end else begin
      eff_bytes = key_length_r;
    end
    for (int k = 0; k < 8; k++) begin
      key_mask[8*k +: 8] = (4'(k) < eff_bytes) ? 8'hFF : 8'h00;
    end
  end

  // Sequencer registers.
  state_t                state_r;
  act_t                  act_r;
  logic [1:0]            op_r;
  logic [KEY_W-1:0]      key_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [BW-1:0]         bucket_r;
  logic [AW-1:0]         base_r;
  logic [FW-1:0]         fill_r;
  logic [FW-1:0]         fill_rd_r;
  logic [FW-1:0]         idx_r;
  logic [FW-1:0]         src_r;
  logic [FW-1:0]         dst_r;
  logic                  first_r;
  logic [DW-1:0]         hold_r;
  logic [NUM_BUCKETS-1:0] valid_r;
  logic [TOTAL_W-1:0]    pair_total_r;
  logic [1:0]            status_r;
  logic [VALUE_W-1:0]    value_out_r;
  logic                  hash_start_r;

  logic [FW-1:0] fill_mem [NUM_BUCKETS];

  // Entry memory ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  hash_ctl_t hctl;
  hash_res_t hres;

  assign hctl.start   = hash_start_r;
  assign hctl.nbytes  = eff_bytes;
  assign hctl.divisor = eff_div;

  chs_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .key   (key_r),
    .ctl   (hctl),
    .res   (hres)
  );

  chs_entry_ram #(
    .DEPTH (SLOTS),
    .AW    (AW),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic key_hit;
  assign key_hit = (((ram_rdata[DW-1 -: KEY_W] ^ key_r) & key_mask) == '0);

  // Memory port steering, one access of each kind per cycle at most.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = base_r + AW'(idx_r);
    ram_wdata = hold_r;
    ram_re    = 1'b0;
    ram_raddr = base_r + AW'(idx_r);
    unique case (state_r)
      S_SCAN_RD: begin
        if (idx_r != fill_r) begin
          ram_re = 1'b1;
        end else if (op_r == OP_INSERT && fill_r < FW'(BUCKET_DEPTH)) begin
          // Miss on insert with room left: append at the tail.
          ram_we    = 1'b1;
          ram_waddr = base_r + AW'(fill_r);
          ram_wdata = {key_r, val_r};
        end
      end
      S_SWAP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = base_r + AW'(idx_r - FW'(1));
      end
      S_SWAP_W1: begin
        ram_we    = 1'b1;
        ram_waddr = base_r + AW'(idx_r - FW'(1));
        ram_wdata = hold_r;
      end
      S_SWAP_W2: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_RM_RD: begin
        ram_re    = 1'b1;
        ram_raddr = base_r + AW'(src_r);
      end
      S_RM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = base_r + AW'(dst_r);
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      act_r        <= ACT_NONE;
      valid_r      <= '0;
      pair_total_r <= '0;
      hash_start_r <= 1'b0;
    end else begin
      hash_start_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r        <= in_ch.payload.op;
            key_r       <= in_ch.payload.key;
            val_r       <= in_ch.payload.value_in[VALUE_WIDTH-1:0];
            status_r    <= ST_OK;
            value_out_r <= '0;
            act_r       <= ACT_NONE;
            if (in_ch.payload.op == OP_EMPTY) begin
              valid_r      <= '0;
              pair_total_r <= '0;
              state_r      <= S_OUT;
            end else begin
              hash_start_r <= 1'b1;
              state_r      <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hres.done) begin
            bucket_r <= hres.rem[BW-1:0];
            state_r  <= S_FILL;
          end
        end
        S_FILL: begin
          fill_rd_r <= fill_mem[bucket_r];
          base_r    <= AW'(bucket_r * BUCKET_DEPTH);
          state_r   <= S_FILL2;
        end
        S_FILL2: begin
          fill_r  <= valid_r[bucket_r] ? fill_rd_r : '0;
          idx_r   <= '0;
          state_r <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          if (idx_r != fill_r) begin
            state_r <= S_SCAN_CMP;
          end else begin
            if (op_r != OP_INSERT) begin
              status_r <= ST_ABSENT;
            end else if (fill_r >= FW'(BUCKET_DEPTH)) begin
              status_r <= ST_FULL;
            end else begin
              act_r <= ACT_INC;
            end
            state_r <= S_FIN;
          end
        end
        S_SCAN_CMP: begin
          if (key_hit) begin
            hold_r <= ram_rdata;
            unique case (op_r)
              OP_REMOVE: begin
                act_r   <= ACT_DEC;
                src_r   <= '0;
                dst_r   <= idx_r;
                first_r <= 1'b1;
                state_r <= S_RM_RD;
              end
              default: begin
                if (op_r == OP_FIND) begin
                  value_out_r <= VALUE_W'(ram_rdata[VALUE_WIDTH-1:0]);
                end else begin
                  status_r <= ST_DUP;
                end
                state_r <= (idx_r != '0) ? S_SWAP_RD : S_FIN;
              end
            endcase
          end else begin
            idx_r   <= idx_r + FW'(1);
            state_r <= S_SCAN_RD;
          end
        end
        S_SWAP_RD: state_r <= S_SWAP_W1;
        S_SWAP_W1: state_r <= S_SWAP_W2;
        S_SWAP_W2: state_r <= S_FIN;
        S_RM_RD:   state_r <= S_RM_WR;
        S_RM_WR: begin
          // Head goes to the found slot first, then the rest move up by one.
          first_r <= 1'b0;
          if (first_r) begin
            src_r   <= FW'(1);
            dst_r   <= '0;
            state_r <= (fill_r > FW'(1)) ? S_RM_RD : S_FIN;
          end else begin
            src_r   <= src_r + FW'(1);
            dst_r   <= dst_r + FW'(1);
            state_r <= (src_r + FW'(1) < fill_r) ? S_RM_RD : S_FIN;
          end
        end
        S_FIN: begin
          unique case (act_r)
            ACT_INC: begin
              valid_r[bucket_r] <= 1'b1;
              pair_total_r      <= pair_total_r + TOTAL_W'(1);
            end
            ACT_DEC: begin
              valid_r[bucket_r] <= 1'b1;
              pair_total_r      <= pair_total_r - TOTAL_W'(1);
            end
            default: ;
          endcase
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Fill memory write, taken when an insert or remove commits.
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && act_r == ACT_INC) begin
      fill_mem[bucket_r] <= fill_r + FW'(1);
    end else if (state_r == S_FIN && act_r == ACT_DEC) begin
      fill_mem[bucket_r] <= fill_r - FW'(1);
    end
  end

  // No input is taken while reset is held.
  assign in_ch.ready                 = rst_n && (state_r == S_IDLE);
  assign out_ch.valid                = (state_r == S_OUT);
  assign out_ch.payload.status       = status_r;
  assign out_ch.payload.value_out    = value_out_r;
  assign out_ch.payload.entry_total  = pair_total_r;

endmodule

// ===== sv/chs_hash.sv =====
// Iterative bucket hash: one key byte per cycle into a running sum, then a
// remainder by the bucket count, four quotient bits per cycle.
// Depends on chs_pkg.
module chs_hash (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [63:0]        key,
  input  chs_pkg::hash_ctl_t ctl,
  output chs_pkg::hash_res_t res
);
  import chs_pkg::*;

  typedef enum logic [1:0] {H_IDLE, H_SUM, H_MOD} hstate_t;

  hstate_t          state_r;
  logic [63:0]      key_sr_r;
  logic [3:0]       cnt_r;
  logic [SUM_W-1:0] sum_r;
  logic [MOD_W-1:0] mod_sr_r;
  logic [3:0]       step_r;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] div_r;
  logic             done_r;

  logic [TERM_W-1:0] term;
  logic [SUM_W-1:0]  sum_add;
  logic [REM_W-1:0]  rem_nxt;
  logic [REM_W:0]    trial;

  assign term    = TERM_W'(key_sr_r[7:0] * HASH_MUL) + TERM_W'(HASH_ADD);
  assign sum_add = sum_r + SUM_W'(term);

  always_comb begin
    rem_nxt = rem_r;
    trial   = '0;
    for (int k = 0; k < 4; k++) begin
      trial = {rem_nxt, mod_sr_r[MOD_W-1-k]};
      if (trial >= {1'b0, div_r}) begin
        trial = trial - {1'b0, div_r};
      end
      rem_nxt = trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        H_IDLE: begin
          if (ctl.start) begin
            key_sr_r <= key;
            cnt_r    <= ctl.nbytes;
            sum_r    <= '0;
            div_r    <= ctl.divisor;
            state_r  <= H_SUM;
          end
        end
        H_SUM: begin
          sum_r    <= sum_add;
          key_sr_r <= key_sr_r >> 8;
          cnt_r    <= cnt_r - 4'd1;
          if (cnt_r == 4'd1) begin
            mod_sr_r <= MOD_W'(sum_add);
            rem_r    <= '0;
            step_r   <= '0;
            state_r  <= H_MOD;
          end
        end
        H_MOD: begin
          rem_r    <= rem_nxt;
          mod_sr_r <= mod_sr_r << 4;
          step_r   <= step_r + 4'd1;
          if (step_r == 4'(MOD_STEPS - 1)) begin
            done_r  <= 1'b1;
            state_r <= H_IDLE;
          end
        end
        default: state_r <= H_IDLE;
      endcase
    end
  end

  assign res.done = done_r;
  assign res.rem  = rem_r;

endmodule

// ===== sv/chs_entry_ram.sv =====
// Entry store of key/value pairs: one write port and one read port with
// registered read data. Depends on nothing.
module chs_entry_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int DW    = 128
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== tb/sv/chained_hash_set_engine_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the chained hash set engine: directed table, then random
// operations, every result checked against a behavioral table model.
// Depends on chs_pkg, chs_if and the engine RTL.
module chained_hash_set_engine_tb;
  import chs_pkg::*;

  localparam int NBKT  = 64;
  localparam int DEPTH = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  chs_in_if  in_ch ();
  chs_out_if out_ch ();

  chained_hash_set_engine dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model of the table: keys and values per bucket slot, fill per bucket.
  logic [63:0] tbl_key [NBKT*DEPTH];
  logic [63:0] tbl_val [NBKT*DEPTH];
  int unsigned tbl_fill [NBKT];
  int unsigned tbl_pairs;
  logic [6:0] set_buckets;
  logic [3:0] set_klen;

  out_item_t pending_results[$];
  int errors = 0;

  // Idling controls, changed per phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  // Keys recently inserted, reused so that finds and removes mostly hit.
  logic [63:0] known_keys[$];

  function automatic int unsigned used_buckets();
    if (set_buckets == 0) return 1;
    if (set_buckets > NBKT) return NBKT;
    return set_buckets;
  endfunction

  function automatic int unsigned hashed_bytes();
    if (set_klen == 0) return 1;
    if (set_klen > 8) return 8;
    return set_klen;
  endfunction

  function automatic int unsigned bucket_of(logic [63:0] k);
    logic [63:0] acc;
    acc = 0;
    for (int i = 0; i < hashed_bytes(); i++)
      acc += 64'(k[8*i +: 8]) * 64'd6678383 + 64'd6618401;
    return int'(acc % 64'(used_buckets()));
  endfunction

  // Swaps a hit with its predecessor and returns where it ends up.
  function automatic int transpose_hit(int base, int s);
    logic [63:0] tk, tv;
    if (s == 0) return 0;
    tk = tbl_key[base+s-1];
    tv = tbl_val[base+s-1];
    tbl_key[base+s-1] = tbl_key[base+s];
    tbl_val[base+s-1] = tbl_val[base+s];
    tbl_key[base+s] = tk;
    tbl_val[base+s] = tv;
    return s - 1;
  endfunction

  // Applies one operation to the model table and returns its result.
  function automatic out_item_t apply_table_op(in_item_t it);
    out_item_t r;
    logic [63:0] m;
    int b, base, hit, f;
    r = '0;
    m = {64{1'b1}} >> (8 * (8 - hashed_bytes()));
    b = bucket_of(it.key);
    base = b * DEPTH;
    if (op_t'(it.op) == OP_EMPTY) begin
      foreach (tbl_fill[i]) tbl_fill[i] = 0;
      tbl_pairs = 0;
    end else begin
      hit = -1;
      f = tbl_fill[b];
      for (int i = 0; i < f; i++)
        if (hit < 0 && ((tbl_key[base+i] ^ it.key) & m) == 0) hit = i;
      case (op_t'(it.op))
        OP_FIND: begin
          if (hit < 0) r.status = ST_ABSENT;
          else r.value_out = tbl_val[base + transpose_hit(base, hit)];
        end
        OP_INSERT: begin
          if (hit >= 0) begin
            void'(transpose_hit(base, hit));
            r.status = ST_DUP;
          end else if (f >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            tbl_key[base+f] = it.key;
            tbl_val[base+f] = it.value_in;
            tbl_fill[b]++;
            tbl_pairs++;
          end
        end
        default: begin
          if (hit < 0) begin
            r.status = ST_ABSENT;
          end else begin
            // The head fills the hole, then everything moves up one slot.
            if (hit > 0) begin
              tbl_key[base+hit] = tbl_key[base];
              tbl_val[base+hit] = tbl_val[base];
            end
            for (int j = 0; j + 1 < f; j++) begin
              tbl_key[base+j] = tbl_key[base+j+1];
              tbl_val[base+j] = tbl_val[base+j+1];
            end
            tbl_fill[b]--;
            tbl_pairs--;
          end
        end
      endcase
    end
    r.entry_total = TOTAL_W'(tbl_pairs);
    return r;
  endfunction

  // Sender: offers one operation, waits for its transfer, then updates the model.
  // Valid drops only when the sender goes idle, so back-to-back items keep it high.
  task automatic send_op(in_item_t it);
    bit idle;
    idle = ($urandom_range(99) < send_idle_pct);
    if (idle) in_ch.valid <= 1'b0;
    while (idle) begin
      @(posedge clk);
      idle = ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(apply_table_op(it));
    if (op_t'(it.op) == OP_INSERT) begin
      known_keys.push_back(it.key);
      if (known_keys.size() > 64) void'(known_keys.pop_front());
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Configuration writes happen only while nothing is in flight.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BUCKETS) set_buckets = val[BKT_CFG_W-1:0];
    else set_klen = val[KLEN_CFG_W-1:0];
    @(posedge clk);
  endtask

  // Receiver: random stall, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        out_item_t e;
        e = pending_results.pop_front();
        if (out_ch.payload.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_ch.payload.status);
          errors++;
        end
        if (out_ch.payload.value_out !== e.value_out) begin
          $error("value_out expected %h actual %h", e.value_out, out_ch.payload.value_out);
          errors++;
        end
        if (out_ch.payload.entry_total !== e.entry_total) begin
          $error("entry_total expected %0d actual %0d", e.entry_total,
                 out_ch.payload.entry_total);
          errors++;
        end
      end
    end
  end

  // Directed table: op, key, value and, for rows readable at a glance,
  // the expected status (check_status set). Others rely on the model only.
  typedef struct {
    op_t op;
    logic [63:0] key;
    logic [63:0] val;
    bit check_status;
    status_t status;
  } row_t;

  row_t directed[] = '{
    '{OP_FIND,   64'h0, 64'h0, 1, ST_ABSENT},
    '{OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1, ST_ABSENT},
    '{OP_INSERT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1, ST_OK},
    '{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1, ST_OK},
    '{OP_INSERT, 64'h0, 64'h1234, 1, ST_DUP},
    '{OP_FIND,   64'h0, 64'h0, 0, ST_OK},
    '{OP_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 0, ST_OK},
    '{OP_INSERT, 64'hA5A5_5A5A_0F0F_F0F0, 64'h5555_AAAA_5555_AAAA, 0, ST_OK},
    '{OP_REMOVE, 64'h0, 64'h0, 0, ST_OK},
    '{OP_REMOVE, 64'h0, 64'h0, 1, ST_ABSENT},
    '{OP_EMPTY,  64'h0, 64'h0, 1, ST_OK},
    '{OP_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1, ST_ABSENT}
  };

  // Random key; mostly reuses known keys, sometimes narrows to force collisions.
  function automatic logic [63:0] pick_key();
    if (known_keys.size() != 0 && $urandom_range(99) < 55)
      return known_keys[$urandom_range(known_keys.size() - 1)];
    if ($urandom_range(3) == 0) return 64'($urandom_range(15));
    return {$urandom, $urandom};
  endfunction

  task automatic random_ops(int n, int insert_pct);
    in_item_t it;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < insert_pct) it.op = OP_INSERT;
      else if (r < insert_pct + 30) it.op = OP_FIND;
      else if (r < 99) it.op = OP_REMOVE;
      else it.op = OP_EMPTY;
      it.key = pick_key();
      it.value_in = {$urandom, $urandom};
      send_op(it);
    end
  endtask

  initial begin
    in_item_t it;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    set_buckets = 7'd64;
    set_klen = 4'd8;
    tbl_pairs = 0;
    foreach (tbl_fill[i]) tbl_fill[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at reset settings, with no idling.
    foreach (directed[i]) begin
      it.op = directed[i].op;
      it.key = directed[i].key;
      it.value_in = directed[i].val;
      send_op(it);
      if (directed[i].check_status && pending_results[$].status != directed[i].status) begin
        $error("directed row %0d: status table %0d model %0d", i,
               directed[i].status, pending_results[$].status);
        errors++;
      end
    end
    wait_drained();

    // One bucket and one key byte: everything collides, so the bucket fills.
    write_cfg(CFG_BUCKETS, 7'd1);
    write_cfg(CFG_KEYLEN, 7'd1);
    for (int i = 0; i < 10; i++) begin
      it.op = OP_INSERT;
      it.key = {$urandom, 24'h0, 8'(i)};
      it.value_in = 64'(i);
      send_op(it);
    end
    // Out-of-range settings: zero and above the maxima.
    wait_drained();
    write_cfg(CFG_BUCKETS, 7'd0);
    write_cfg(CFG_KEYLEN, 7'd0);
    random_ops(40, 40);
    wait_drained();
    write_cfg(CFG_BUCKETS, 7'd127);
    write_cfg(CFG_KEYLEN, 7'd15);
    random_ops(60, 45);

    // Pressure: long receiver hold-off while the sender keeps offering.
    hold_cycles = 300;
    random_ops(20, 50);
    wait_drained();

    // Phases of idling over several settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      write_cfg(CFG_BUCKETS, 7'($urandom_range(1, 64)));
      write_cfg(CFG_KEYLEN, 7'($urandom_range(1, 8)));
      random_ops(220, 45);
      random_ops(200, 30);
      wait_drained();
      write_cfg(CFG_BUCKETS, ph[0] ? 7'd64 : 7'd3);
      write_cfg(CFG_KEYLEN, ph[1] ? 7'd8 : 7'd2);
      random_ops(30, 50);
      wait_drained();
    end

    if (errors == 0) $display("chained_hash_set_engine_tb OK");
    else $display("chained_hash_set_engine_tb NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("chained_hash_set_engine_tb NOT OK");
    $finish;
  end

endmodule
